// ===== rtl/core/kss1_pkg.sv =====
package kss1_pkg;

  localparam int unsigned SEQ_DEPTH = 6;
  localparam int unsigned CNT_W     = 3;

  localparam logic [7:0] REL_OFFSET   = 8'h80;
  localparam logic [7:0] REL_LO       = 8'h81;
  localparam logic [7:0] REL_HI       = 8'hD8;
  localparam logic [7:0] EXT_REL_LO   = 8'h99;
  localparam logic [7:0] EXT_REL_HI   = 8'hED;
  localparam logic [7:0] PFX_EXT      = 8'hE0;
  localparam logic [7:0] PFX_PAUSE    = 8'hE1;
  localparam logic [7:0] PRTSC_MK1    = 8'h2A;
  localparam logic [7:0] PRTSC_MK2    = 8'h37;
  localparam logic [7:0] PRTSC_BRK1   = 8'hB7;
  localparam logic [7:0] PRTSC_BRK2   = 8'hAA;
  localparam logic [7:0] PAUSE_B1     = 8'h1D;
  localparam logic [7:0] PAUSE_B2     = 8'h45;
  localparam logic [7:0] PAUSE_B4     = 8'h9D;
  localparam logic [7:0] PAUSE_B5     = 8'hC5;

  localparam logic [1:0] GRP_SINGLE   = 2'd0;
  localparam logic [1:0] GRP_EXT      = 2'd1;
  localparam logic [1:0] GRP_PRTSC    = 2'd2;
  localparam logic [1:0] GRP_PAUSE    = 2'd3;

  typedef struct packed {
    logic       hit;
    logic [6:0] make_code;
    logic [1:0] key_group;
    logic       released;
  } kss1_evt_t;

  function automatic logic single_known(input logic [7:0] c);
    single_known = ((c >= 8'h01) && (c <= 8'h53)) || (c == 8'h57) || (c == 8'h58);
  endfunction

  function automatic logic extended_known(input logic [7:0] c);
    case (c)
      8'h1C, 8'h1D, 8'h35, 8'h38,
      8'h47, 8'h48, 8'h49, 8'h4B,
      8'h4D, 8'h4F, 8'h50, 8'h51,
      8'h52, 8'h53, 8'h5B, 8'h5D: extended_known = 1'b1;
      default:                    extended_known = 1'b0;
    endcase
  endfunction

endpackage

// ===== rtl/core/kss1_decode.sv =====
module kss1_decode
  import kss1_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] scan_byte,
  output kss1_evt_t  evt
);

  logic [7:0]       pend_r [SEQ_DEPTH];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  logic [7:0] c1;
  logic [7:0] c2;
  logic       rel1;
  logic       rel2;
  logic       hit_single;
  logic       hit_ext;
  logic       hit_ps_mk;
  logic       hit_ps_brk;
  logic       hit_pause;

  always_comb begin
    rel1 = (scan_byte >= REL_LO) && (scan_byte <= REL_HI);
    c1   = rel1 ? (scan_byte - REL_OFFSET) : scan_byte;
    rel2 = (scan_byte >= EXT_REL_LO) && (scan_byte <= EXT_REL_HI);
    c2   = rel2 ? (scan_byte - REL_OFFSET) : scan_byte;

    hit_single = (cnt_r == CNT_W'(0)) && single_known(c1);
    hit_ext    = (cnt_r == CNT_W'(1)) && (pend_r[0] == PFX_EXT) && extended_known(c2);
    hit_ps_mk  = (cnt_r == CNT_W'(3)) && (pend_r[0] == PFX_EXT) && (pend_r[2] == PFX_EXT) &&
                 (pend_r[1] == PRTSC_MK1) && (scan_byte == PRTSC_MK2);
    hit_ps_brk = (cnt_r == CNT_W'(3)) && (pend_r[0] == PFX_EXT) && (pend_r[2] == PFX_EXT) &&
                 (pend_r[1] == PRTSC_BRK1) && (scan_byte == PRTSC_BRK2);
    hit_pause  = (cnt_r == CNT_W'(5)) && (pend_r[0] == PFX_PAUSE) &&
                 (pend_r[1] == PAUSE_B1) && (pend_r[2] == PAUSE_B2) &&
                 (pend_r[3] == PFX_PAUSE) && (pend_r[4] == PAUSE_B4) &&
                 (scan_byte == PAUSE_B5);

    evt = '0;
    if (hit_single) begin
      evt.hit       = 1'b1;
      evt.make_code = c1[6:0];
      evt.key_group = GRP_SINGLE;
      evt.released  = rel1;
    end else if (hit_ext) begin
      evt.hit       = 1'b1;
      evt.make_code = c2[6:0];
      evt.key_group = GRP_EXT;
      evt.released  = rel2;
    end else if (hit_ps_mk || hit_ps_brk) begin
      evt.hit       = 1'b1;
      evt.key_group = GRP_PRTSC;
      evt.released  = hit_ps_brk;
    end else if (hit_pause) begin
      evt.hit       = 1'b1;
      evt.key_group = GRP_PAUSE;
    end

    if (evt.hit || (cnt_r == CNT_W'(SEQ_DEPTH))) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_nxt;
    end
  end

  // pending store, no reset: only entries below cnt_r are read
  always_ff @(posedge clk) begin
    if (step && !evt.hit && (cnt_r < CNT_W'(SEQ_DEPTH))) begin
      pend_r[cnt_r] <= scan_byte;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SEQ_DEPTH))
    else $error("pending count out of range");

  a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && evt.hit) |=> (cnt_r == '0))
    else $error("match did not clear pending sequence");

  a_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !evt.hit && (cnt_r < CNT_W'(SEQ_DEPTH))) |=>
      (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("pending count did not advance");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(cnt_r))
    else $error("pending count changed without a transfer");
`endif

endmodule

// ===== rtl/core/keyboard_scancode_set1_decoder.sv =====
// Scancode set 1 decoder.
// Input channel: in_valid / in_stall with in_scan_byte, one raw byte per
// transfer. Output channel: out_valid / out_stall with out_make_code,
// out_key_group and out_released, one event per completed key sequence.
// Bytes that only extend a prefix, or are unknown, produce no event.
// A byte goes into an input register, is matched against the pending
// sequence from there and its event lands in the output register.
// Throughput is one byte per cycle while no event is held by out_stall;
// the pending-sequence update is a single registered step, so bytes may
// follow back to back.
// When the receiver raises out_stall with an event held, the event stays
// put; the byte behind it waits in the input register and in_stall rises
// only once that register is also occupied.
// A sequence still unmatched after seven bytes is discarded silently.
// Reset (rst_n low, synchronous) empties both registers and the pending
// sequence; no clearing pass is needed.
module keyboard_scancode_set1_decoder
  import kss1_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_make_code,
  output logic [1:0] out_key_group,
  output logic       out_released
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_go;
  logic       in_fire;
  kss1_evt_t  evt;

  logic       out_valid_r;
  logic [6:0] out_code_r;
  logic [1:0] out_grp_r;
  logic       out_rel_r;

  assign s1_go    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_scan_byte;
    end
  end

  kss1_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .scan_byte (s1_byte_r),
    .evt       (evt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= evt.hit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && evt.hit) begin
      out_code_r <= evt.make_code;
      out_grp_r  <= evt.key_group;
      out_rel_r  <= evt.released;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_make_code = out_code_r;
  assign out_key_group = out_grp_r;
  assign out_released  = out_rel_r;

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with free pipeline slot");

  a_evt_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && evt.hit) |=> out_valid)
    else $error("matched event not presented");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled event lost");
`endif

endmodule
